// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) else $error(msg);

// Condition must never be seen outside reset.
`define ASSERT_NEVER(lbl, clk_s, rst_s, cond, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) !(cond)) else $error(msg);

`endif

// ----- rtl/cvm_pkg.sv -----
// Package: beat types, widths and status codes of the cluster merge block.
`default_nettype none

package cvm_pkg;

  localparam int PNT_W     = 20;
  localparam int FRAC_BITS = 4;
  localparam int COORD_W   = 16;
  localparam int CNT_W     = 9;
  localparam int SUM_W     = 24;
  localparam int SQ_W      = 40;
  localparam int THR_W     = 31;
  localparam int MAX_COUNT = 256;

  // serial multiplier: accumulator covers |Lx|^2 + |Ly|^2 + T*n^2
  localparam int MUL_W = 49;
  localparam int MB_W  = SUM_W;

  localparam logic [1:0] ST_STARTED = 2'd0;
  localparam logic [1:0] ST_MERGED  = 2'd1;
  localparam logic [1:0] ST_REF_VAR = 2'd2;
  localparam logic [1:0] ST_REF_CAP = 2'd3;

  typedef struct packed {
    logic                    op;
    logic signed [PNT_W-1:0] point_x;
    logic signed [PNT_W-1:0] point_y;
    logic [CNT_W-1:0]        other_count;
    logic signed [SUM_W-1:0] other_sum_x;
    logic signed [SUM_W-1:0] other_sum_y;
    logic [SQ_W-1:0]         other_sum_sq;
  } in_t;

  typedef struct packed {
    logic [1:0]                status;
    logic signed [COORD_W-1:0] centroid_x;
    logic signed [COORD_W-1:0] centroid_y;
    logic [CNT_W-1:0]          count;
    logic signed [SUM_W-1:0]   sum_x;
    logic signed [SUM_W-1:0]   sum_y;
    logic [SQ_W-1:0]           sum_sq;
  } out_t;

endpackage

`default_nettype wire

// ----- rtl/cluster_variance_merge.sv -----
// Top level: single 2-D clustering-feature store with serial merge test.
//
// Holds one cluster summary (count, signed sums, sum of squares, centroid).
// An op 0 beat restarts the cluster from a fixed-point point, rounded half up
// toward zero and saturated to 16 bits. An op 1 beat offers another summary;
// the merge is refused for capacity (count above 256 or a sum out of range)
// or for variance (n*S - (Lx^2 + Ly^2) > T*n^2, exact), else the sums are
// added and the centroid becomes Lx/n, Ly/n truncated toward zero. Every input
// beat gives one output beat showing the cluster after that beat. One beat is
// worked on at a time. All products go through one bit-serial shift-add
// multiplier that runs until its multiplier operand is exhausted; the centroid
// comes from a restoring divider. A start squares only cx and cy, a capacity
// refusal skips the arithmetic, and a full merge runs n^2, T*n^2, Lx^2, Ly^2,
// n*S, then both divisions. The output register lets the next beat be taken
// while a result still waits for out_ready. The threshold register is written
// by cfg_wen/cfg_wdata and must only change while idle.
`default_nettype none

module cluster_variance_merge
  import cvm_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire in_t              in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output out_t                  out_data,
  input  wire logic             cfg_wen,
  input  wire logic [THR_W-1:0] cfg_wdata
);

  localparam int DCNT_W = $clog2(SUM_W);

  // sequencer codes
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;  // merged sums and capacity test
  localparam logic [3:0] S_PREP  = 4'd2;  // start: load cx^2
  localparam logic [3:0] S_NSQ   = 4'd3;  // n*n
  localparam logic [3:0] S_TNN   = 4'd4;  // T*n^2
  localparam logic [3:0] S_AX    = 4'd5;  // += |Lx|^2
  localparam logic [3:0] S_AY    = 4'd6;  // += |Ly|^2
  localparam logic [3:0] S_LHS   = 4'd7;  // n*S, then compare
  localparam logic [3:0] S_DIVX  = 4'd8;
  localparam logic [3:0] S_DIVY  = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  // round half up, truncate toward zero, saturate to the coordinate range
  function automatic logic signed [COORD_W-1:0] round_coord(
    input logic signed [PNT_W-1:0] p
  );
    logic signed [PNT_W:0]         v;
    logic signed [PNT_W:0]         vb;
    logic signed [PNT_W-FRAC_BITS:0] q;
    v  = (PNT_W+1)'(p) + (PNT_W+1)'(1 << (FRAC_BITS - 1));
    vb = v[PNT_W] ? v + (PNT_W+1)'((1 << FRAC_BITS) - 1) : v;
    q  = (PNT_W-FRAC_BITS+1)'(vb >>> FRAC_BITS);
    if (!q[PNT_W-FRAC_BITS] && (|q[PNT_W-FRAC_BITS-1:COORD_W-1]))
      round_coord = {1'b0, {(COORD_W-1){1'b1}}};
    else if (q[PNT_W-FRAC_BITS] && !(&q[PNT_W-FRAC_BITS-1:COORD_W-1]))
      round_coord = {1'b1, {(COORD_W-1){1'b0}}};
    else
      round_coord = q[COORD_W-1:0];
  endfunction

  function automatic logic [SUM_W-1:0] abs_sum(input logic [SUM_W-1:0] v);
    abs_sum = v[SUM_W-1] ? (~v + SUM_W'(1)) : v;
  endfunction

  // apply sign to a quotient magnitude and saturate
  function automatic logic [COORD_W-1:0] sat_quot(
    input logic [SUM_W-1:0] q,
    input logic             neg
  );
    logic [COORD_W-1:0] m;
    m = q[COORD_W-1:0];
    if (!neg)
      sat_quot = (q > SUM_W'((1 << (COORD_W - 1)) - 1)) ?
                 {1'b0, {(COORD_W-1){1'b1}}} : m;
    else
      sat_quot = (q > SUM_W'(1 << (COORD_W - 1))) ?
                 {1'b1, {(COORD_W-1){1'b0}}} : (~m + COORD_W'(1));
  endfunction

  logic [3:0]         state;
  logic [THR_W-1:0]   thresh;

  // cluster held between beats
  logic [COORD_W-1:0] cur_cx;
  logic [COORD_W-1:0] cur_cy;
  logic [CNT_W-1:0]   cur_count;
  logic [SUM_W-1:0]   cur_sx;
  logic [SUM_W-1:0]   cur_sy;
  logic [SQ_W-1:0]    cur_sq;

  // working registers for the beat in flight
  logic               op_r;
  logic [1:0]         status_r;
  logic [CNT_W-1:0]   oth_cnt;
  logic [SUM_W-1:0]   oth_sx;
  logic [SUM_W-1:0]   oth_sy;
  logic [SQ_W-1:0]    oth_sq;
  logic [CNT_W-1:0]   n_r;
  logic [SUM_W-1:0]   lx_r;
  logic [SUM_W-1:0]   ly_r;
  logic [SQ_W-1:0]    s_r;
  logic [MUL_W-1:0]   rhs_r;
  logic [COORD_W-1:0] qx;
  logic [COORD_W-1:0] qy;

  // bit-serial multiplier
  logic [MUL_W-1:0]   acc;
  logic [MUL_W-1:0]   mul_a;
  logic [MB_W-1:0]    mul_b;
  logic [MUL_W-1:0]   acc_step;
  logic               mul_run;

  // restoring divider
  logic [SUM_W-1:0]   div_q;
  logic [CNT_W-1:0]   div_rem;
  logic [DCNT_W-1:0]  div_cnt;
  logic [CNT_W:0]     rem_sh;
  logic               div_ge;
  logic [CNT_W-1:0]   rem_nx;
  logic [SUM_W-1:0]   q_nx;

  // merged sums
  logic [CNT_W:0]     n_sum;
  logic [SUM_W:0]     lx_sum;
  logic [SUM_W:0]     ly_sum;
  logic [SQ_W:0]      s_sum;
  logic               cap_fail;

  out_t               res;
  logic               hand_over;

  assign in_ready = (state == S_IDLE);

  // result goes out once the output register is free
  assign hand_over = (state == S_DONE) && (!out_valid || out_ready);

  assign mul_run  = (mul_b != '0);
  assign acc_step = mul_b[0] ? acc + mul_a : acc;

  assign rem_sh = {div_rem, div_q[SUM_W-1]};
  assign div_ge = (rem_sh >= {1'b0, n_r});
  assign rem_nx = div_ge ? CNT_W'(rem_sh - {1'b0, n_r}) : rem_sh[CNT_W-1:0];
  assign q_nx   = {div_q[SUM_W-2:0], div_ge};

  assign n_sum  = {1'b0, cur_count} + {1'b0, oth_cnt};
  assign lx_sum = {cur_sx[SUM_W-1], cur_sx} + {oth_sx[SUM_W-1], oth_sx};
  assign ly_sum = {cur_sy[SUM_W-1], cur_sy} + {oth_sy[SUM_W-1], oth_sy};
  assign s_sum  = {1'b0, cur_sq} + {1'b0, oth_sq};
  assign cap_fail = (n_sum > (CNT_W+1)'(MAX_COUNT)) ||
                    (lx_sum[SUM_W] != lx_sum[SUM_W-1]) ||
                    (ly_sum[SUM_W] != ly_sum[SUM_W-1]) ||
                    s_sum[SQ_W];

  // cluster after this beat
  always_comb begin
    res.status = status_r;
    unique case (status_r)
      ST_STARTED: begin
        res.centroid_x = lx_r[COORD_W-1:0];
        res.centroid_y = ly_r[COORD_W-1:0];
        res.count      = CNT_W'(1);
        res.sum_x      = lx_r;
        res.sum_y      = ly_r;
        res.sum_sq     = acc[SQ_W-1:0];
      end
      ST_MERGED: begin
        res.centroid_x = qx;
        res.centroid_y = qy;
        res.count      = n_r;
        res.sum_x      = lx_r;
        res.sum_y      = ly_r;
        res.sum_sq     = s_r;
      end
      ST_REF_VAR, ST_REF_CAP: begin
        res.centroid_x = cur_cx;
        res.centroid_y = cur_cy;
        res.count      = cur_count;
        res.sum_x      = cur_sx;
        res.sum_y      = cur_sy;
        res.sum_sq     = cur_sq;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      thresh    <= '0;
      cur_cx    <= '0;
      cur_cy    <= '0;
      cur_count <= '0;
      cur_sx    <= '0;
      cur_sy    <= '0;
      cur_sq    <= '0;
    end else begin
      if (cfg_wen) begin
        thresh <= cfg_wdata;
      end
      if (hand_over) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_r     <= in_data.op;
            oth_cnt  <= in_data.other_count;
            oth_sx   <= in_data.other_sum_x;
            oth_sy   <= in_data.other_sum_y;
            oth_sq   <= in_data.other_sum_sq;
            lx_r     <= SUM_W'(round_coord(in_data.point_x));
            ly_r     <= SUM_W'(round_coord(in_data.point_y));
            status_r <= in_data.op ? ST_MERGED : ST_STARTED;
            state    <= in_data.op ? S_CHECK : S_PREP;
          end
        end

        S_PREP: begin
          acc   <= '0;
          mul_a <= MUL_W'(abs_sum(lx_r));
          mul_b <= abs_sum(lx_r);
          state <= S_AX;
        end

        S_CHECK: begin
          if (cap_fail) begin
            status_r <= ST_REF_CAP;
            state    <= S_DONE;
          end else begin
            n_r   <= n_sum[CNT_W-1:0];
            lx_r  <= lx_sum[SUM_W-1:0];
            ly_r  <= ly_sum[SUM_W-1:0];
            s_r   <= s_sum[SQ_W-1:0];
            acc   <= '0;
            mul_a <= MUL_W'(n_sum[CNT_W-1:0]);
            mul_b <= MB_W'(n_sum[CNT_W-1:0]);
            state <= S_NSQ;
          end
        end

        S_NSQ: begin
          if (mul_run) begin
            acc   <= acc_step;
            mul_a <= mul_a << 1;
            mul_b <= mul_b >> 1;
          end else begin
            acc   <= '0;
            mul_a <= MUL_W'(thresh);
            mul_b <= MB_W'(acc[2*CNT_W-1:0]);
            state <= S_TNN;
          end
        end

        S_TNN: begin
          if (mul_run) begin
            acc   <= acc_step;
            mul_a <= mul_a << 1;
            mul_b <= mul_b >> 1;
          end else begin
            mul_a <= MUL_W'(abs_sum(lx_r));
            mul_b <= abs_sum(lx_r);
            state <= S_AX;
          end
        end

        S_AX: begin
          if (mul_run) begin
            acc   <= acc_step;
            mul_a <= mul_a << 1;
            mul_b <= mul_b >> 1;
          end else begin
            mul_a <= MUL_W'(abs_sum(ly_r));
            mul_b <= abs_sum(ly_r);
            state <= S_AY;
          end
        end

        S_AY: begin
          if (mul_run) begin
            acc   <= acc_step;
            mul_a <= mul_a << 1;
            mul_b <= mul_b >> 1;
          end else if (!op_r) begin
            // start: acc now holds cx^2 + cy^2
            state <= S_DONE;
          end else begin
            rhs_r <= acc;
            acc   <= '0;
            mul_a <= MUL_W'(s_r);
            mul_b <= MB_W'(n_r);
            state <= S_LHS;
          end
        end

        S_LHS: begin
          if (mul_run) begin
            acc   <= acc_step;
            mul_a <= mul_a << 1;
            mul_b <= mul_b >> 1;
          end else if (acc > rhs_r) begin
            status_r <= ST_REF_VAR;
            state    <= S_DONE;
          end else if (n_r == '0) begin
            // empty merge: centroid is zero
            qx    <= '0;
            qy    <= '0;
            state <= S_DONE;
          end else begin
            div_q   <= abs_sum(lx_r);
            div_rem <= '0;
            div_cnt <= DCNT_W'(SUM_W - 1);
            state   <= S_DIVX;
          end
        end

        S_DIVX: begin
          if (div_cnt == '0) begin
            qx      <= sat_quot(q_nx, lx_r[SUM_W-1]);
            div_q   <= abs_sum(ly_r);
            div_rem <= '0;
            div_cnt <= DCNT_W'(SUM_W - 1);
            state   <= S_DIVY;
          end else begin
            div_q   <= q_nx;
            div_rem <= rem_nx;
            div_cnt <= div_cnt - DCNT_W'(1);
          end
        end

        S_DIVY: begin
          div_q   <= q_nx;
          div_rem <= rem_nx;
          div_cnt <= div_cnt - DCNT_W'(1);
          if (div_cnt == '0) begin
            qy    <= sat_quot(q_nx, ly_r[SUM_W-1]);
            state <= S_DONE;
          end
        end

        S_DONE: begin
          // hand over once the output register is free
          if (hand_over) begin
            out_data  <= res;
            cur_cx    <= res.centroid_x;
            cur_cy    <= res.centroid_y;
            cur_count <= res.count;
            cur_sx    <= res.sum_x;
            cur_sy    <= res.sum_y;
            cur_sq    <= res.sum_sq;
            state     <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/cvm_checker.sv -----
// Port checker for the cluster merge block, bound to the top level.
`default_nettype none

`include "assert_macros.svh"

module cvm_props
  import cvm_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire out_t out_data
);

  // a waiting result beat holds still
  `ASSERT_PROP(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(out_data), "output beat changed while stalled")

  // one beat at a time: no accept straight after an accept
  `ASSERT_PROP(a_one_beat, clk, rst, in_valid && in_ready |=> !in_ready, "input taken while a beat is in flight")

  // a fresh start reports one point and centroid equal to the sums
  `ASSERT_PROP(a_start, clk, rst, out_valid && (out_data.status == ST_STARTED) |-> (out_data.count == CNT_W'(1)) && (out_data.sum_x == SUM_W'(out_data.centroid_x)) && (out_data.sum_y == SUM_W'(out_data.centroid_y)), "start beat inconsistent")

  `ASSERT_NEVER(a_count_cap, clk, rst, out_valid && (out_data.count > CNT_W'(MAX_COUNT)), "count above capacity")

endmodule

bind cluster_variance_merge cvm_props u_cvm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
